>>> hw/rtl/gfs_pkg.sv
`default_nettype none
package gfs_pkg;

  localparam int POS_W   = 24;
  localparam int MASS_W  = 10;
  localparam int CMD_W   = 2;
  localparam int MIN_W   = 16;
  localparam int SUM_W   = 48;
  localparam int CNTO_W  = 7;
  localparam int D2_W    = 50;   // squared distance, 24 fraction bits
  localparam int DIST_W  = D2_W / 2;
  localparam int CUBE_W  = 3 * DIST_W;
  localparam int NUM_W   = 83;   // mass*|delta| shifted up by 48
  localparam int QUO_W   = 64;   // quotient keeps its low 64 bits
  localparam int FSHIFT  = 48;
  localparam int PSHIFT  = 36;

  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

  localparam logic [MIN_W-1:0] MIN_DIST_RESET = 16'd1;

  localparam logic [SUM_W-1:0] SAT_HI = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] SAT_LO = {1'b1, {(SUM_W-1){1'b0}}};

  typedef struct packed {
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
    logic [MASS_W-1:0] mass;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_LOAD,
    ST_SQUARE_X,
    ST_SQUARE_Y,
    ST_SQRT_GO,
    ST_SQRT_WAIT,
    ST_CUBE_LO,
    ST_CUBE_SUM,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_ACC,
    ST_NEXT,
    ST_DONE
  } state_t;

  // 64-bit wrapping add, then clamp to the 48-bit range
  function automatic logic [SUM_W-1:0] sat_acc(input logic [SUM_W-1:0] acc,
                                               input logic [QUO_W-1:0] term);
    logic [QUO_W-1:0] s;
    s = {{(QUO_W-SUM_W){acc[SUM_W-1]}}, acc} + term;
    if (s[QUO_W-1:SUM_W-1] == {(QUO_W-SUM_W+1){s[QUO_W-1]}}) begin
      return s[SUM_W-1:0];
    end else if (s[QUO_W-1]) begin
      return SAT_LO;
    end else begin
      return SAT_HI;
    end
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/gfs_table.sv
`default_nettype none
module gfs_table #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [AW-1:0]   waddr,
  input  wire gfs_pkg::entry_t wdata,
  input  wire logic [AW-1:0]   raddr,
  output gfs_pkg::entry_t      rdata
);
  import gfs_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> hw/rtl/gfs_sqrt.sv
`default_nettype none
module gfs_sqrt #(
  parameter int W = 50
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire logic [W-1:0]   radicand,
  output logic                done,
  output logic [W/2-1:0]      root_out
);
  import gfs_pkg::*;

  localparam int RW    = W / 2;
  localparam int CNT_W = $clog2(RW + 1);

  logic [W-1:0]     rem;
  logic [W-1:0]     root;
  logic [W-1:0]     bit_r;
  logic [CNT_W-1:0] cnt;
  logic             active;
  logic [W:0]       trial;
  logic             ge;

  assign trial    = {1'b0, root} + {1'b0, bit_r};
  assign ge       = {1'b0, rem} >= trial;
  assign root_out = root[RW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= '0;
        rem    <= radicand;
        root   <= '0;
        bit_r  <= {2'b01, {(W-2){1'b0}}};
      end else if (active) begin
        if (ge) begin
          rem  <= rem - trial[W-1:0];
          root <= (root >> 1) + bit_r;
        end else begin
          root <= root >> 1;
        end
        bit_r <= bit_r >> 2;
        cnt   <= cnt + 1'b1;
        if (cnt == CNT_W'(RW - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/gfs_div.sv
`default_nettype none
module gfs_div #(
  parameter int NUM_W = 83,
  parameter int DEN_W = 75,
  parameter int QUO_W = 64
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [QUO_W-1:0]      quo
);
  import gfs_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] n;
  logic [DEN_W-1:0] d;
  logic [DEN_W-1:0] r;
  logic [CNT_W-1:0] cnt;
  logic             active;
  logic [DEN_W:0]   sh;
  logic [DEN_W:0]   diff;
  logic             ge;

  // restoring division, one quotient bit per cycle
  assign sh   = {r, n[NUM_W-1]};
  assign ge   = sh >= {1'b0, d};
  assign diff = sh - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= '0;
        n      <= num;
        d      <= den;
        r      <= '0;
        quo    <= '0;
      end else if (active) begin
        n   <= n << 1;
        r   <= ge ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
        quo <= {quo[QUO_W-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(NUM_W - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/gravity_field_summation.sv
// clear and add leave busy low, so the next item follows at once
// a query walks every stored attractor: table read, squares, sqrt, cube,
// divisions, accumulate; those within min_distance skip cube and divisions;
// the divider wait is the longest step, the sqrt wait the next after it
// done pulses for one cycle with the sums; the receiver cannot stall
// rst (synchronous) empties the table and sets min_distance to 1
`default_nettype none
module gravity_field_summation #(
  parameter int MAX_ATTRACTORS = 64
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic [gfs_pkg::CMD_W-1:0]            command,
  input  wire logic signed [gfs_pkg::POS_W-1:0]     pos_x,
  input  wire logic signed [gfs_pkg::POS_W-1:0]     pos_y,
  input  wire logic [gfs_pkg::MASS_W-1:0]           body_mass,
  input  wire logic                                 cfg_write,
  input  wire logic [gfs_pkg::MIN_W-1:0]            cfg_data,
  output logic                                      done,
  output logic signed [gfs_pkg::SUM_W-1:0]          force_x,
  output logic signed [gfs_pkg::SUM_W-1:0]          force_y,
  output logic signed [gfs_pkg::SUM_W-1:0]          potential,
  output logic [gfs_pkg::CNTO_W-1:0]                attractor_count
);
  import gfs_pkg::*;

  // table address and fill-count widths
  localparam int AW = (MAX_ATTRACTORS > 1) ? $clog2(MAX_ATTRACTORS) : 1;
  localparam int CW = $clog2(MAX_ATTRACTORS + 1);

  state_t state;
  state_t state_next;

  logic [CW-1:0]    count;
  logic [CW-1:0]    idx;
  logic [MIN_W-1:0] min_dist;

  // latched query point
  logic [POS_W-1:0] px;
  logic [POS_W-1:0] py;

  // per-attractor datapath registers
  logic [POS_W-1:0]  adx;
  logic [POS_W-1:0]  ady;
  logic              sx;
  logic              sy;
  logic [MASS_W-1:0] mass;
  logic [2*POS_W-1:0] sqx;
  logic [2*POS_W-1:0] sqy;
  logic [D2_W-1:0]   d2;
  logic [2*DIST_W-1:0] dd;
  logic [2*DIST_W-1:0] clo;
  logic [2*DIST_W-1:0] chi;
  logic [CUBE_W-1:0] cube;

  // running sums
  logic [SUM_W-1:0] fx;
  logic [SUM_W-1:0] fy;
  logic [SUM_W-1:0] pot;

  // control from the output decoder
  logic accept;
  logic full;
  logic mem_we;
  logic sqrt_start;
  logic div_start;

  // table port
  entry_t wentry;
  entry_t rentry;

  // sqrt and divider links
  logic              sqrt_done;
  logic [DIST_W-1:0] root_d;
  logic              divx_done;
  logic              divy_done;
  logic              divp_done;
  logic [QUO_W-1:0]  qx;
  logic [QUO_W-1:0]  qy;
  logic [QUO_W-1:0]  qp;
  logic [NUM_W-1:0]  num_x;
  logic [NUM_W-1:0]  num_y;
  logic [NUM_W-1:0]  num_p;
  logic [CUBE_W-1:0] den_p;
  logic [MASS_W+POS_W-1:0] mx;
  logic [MASS_W+POS_W-1:0] my;

  // signed deltas from the query point to the table entry
  logic [POS_W:0] dx_w;
  logic [POS_W:0] dy_w;
  logic [POS_W:0] adx_w;
  logic [POS_W:0] ady_w;

  logic [CW-1:0]        idx_inc;
  logic [CW+CNTO_W-1:0] count_ext;

  assign accept  = start && !busy;
  assign full    = count >= CW'(MAX_ATTRACTORS);
  assign idx_inc = idx + 1'b1;

  assign wentry.x    = pos_x;
  assign wentry.y    = pos_y;
  assign wentry.mass = body_mass;

  assign dx_w  = {rentry.x[POS_W-1], rentry.x} - {px[POS_W-1], px};
  assign dy_w  = {rentry.y[POS_W-1], rentry.y} - {py[POS_W-1], py};
  assign adx_w = dx_w[POS_W] ? -dx_w : dx_w;
  assign ady_w = dy_w[POS_W] ? -dy_w : dy_w;

  // full-width square of |dy|
  assign sqy = ady * ady;

  // numerators: mass*|delta| * 2^48 for force, mass * 2^36 for potential
  assign mx    = mass * adx;
  assign my    = mass * ady;
  assign num_x = {{(NUM_W-MASS_W-POS_W-FSHIFT){1'b0}}, mx, {FSHIFT{1'b0}}};
  assign num_y = {{(NUM_W-MASS_W-POS_W-FSHIFT){1'b0}}, my, {FSHIFT{1'b0}}};
  assign num_p = {{(NUM_W-MASS_W-PSHIFT){1'b0}}, mass, {PSHIFT{1'b0}}};
  assign den_p = {{(CUBE_W-DIST_W){1'b0}}, root_d};

  assign count_ext       = {{CNTO_W{1'b0}}, count};
  assign attractor_count = count_ext[CNTO_W-1:0];
  assign force_x         = fx;
  assign force_y         = fy;
  assign potential       = pot;

  gfs_table #(
    .DEPTH (MAX_ATTRACTORS),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (count[AW-1:0]),
    .wdata (wentry),
    .raddr (idx[AW-1:0]),
    .rdata (rentry)
  );

  gfs_sqrt #(
    .W (D2_W)
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (d2),
    .done     (sqrt_done),
    .root_out (root_d)
  );

  gfs_div #(.NUM_W(NUM_W), .DEN_W(CUBE_W), .QUO_W(QUO_W)) u_div_x (
    .clk (clk), .rst (rst), .start (div_start),
    .num (num_x), .den (cube), .done (divx_done), .quo (qx)
  );

  gfs_div #(.NUM_W(NUM_W), .DEN_W(CUBE_W), .QUO_W(QUO_W)) u_div_y (
    .clk (clk), .rst (rst), .start (div_start),
    .num (num_y), .den (cube), .done (divy_done), .quo (qy)
  );

  gfs_div #(.NUM_W(NUM_W), .DEN_W(CUBE_W), .QUO_W(QUO_W)) u_div_p (
    .clk (clk), .rst (rst), .start (div_start),
    .num (num_p), .den (den_p), .done (divp_done), .quo (qp)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && command == CMD_QUERY) begin
          state_next = (count == '0) ? ST_DONE : ST_ISSUE;
        end
      end
      ST_ISSUE:    state_next = ST_LOAD;
      ST_LOAD:     state_next = ST_SQUARE_X;
      ST_SQUARE_X: state_next = ST_SQUARE_Y;
      ST_SQUARE_Y: state_next = ST_SQRT_GO;
      ST_SQRT_GO:  state_next = ST_SQRT_WAIT;
      ST_SQRT_WAIT: begin
        if (sqrt_done) begin
          // attractors within min_distance add nothing
          state_next = (root_d <= {{(DIST_W-MIN_W){1'b0}}, min_dist}) ? ST_NEXT : ST_CUBE_LO;
        end
      end
      ST_CUBE_LO:  state_next = ST_CUBE_SUM;
      ST_CUBE_SUM: state_next = ST_DIV_GO;
      ST_DIV_GO:   state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (divx_done) begin
          state_next = ST_ACC;
        end
      end
      ST_ACC:      state_next = ST_NEXT;
      ST_NEXT:     state_next = (idx_inc == count) ? ST_DONE : ST_ISSUE;
      ST_DONE:     state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    busy       = (state != ST_IDLE);
    done       = (state == ST_DONE);
    mem_we     = (state == ST_IDLE) && accept && command == CMD_ADD && !full;
    sqrt_start = (state == ST_SQRT_GO);
    div_start  = (state == ST_DIV_GO);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      min_dist <= MIN_DIST_RESET;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        min_dist <= cfg_data;
      end
      if (state == ST_IDLE && accept && command == CMD_CLEAR) begin
        count <= '0;
      end else if (mem_we) begin
        count <= count + 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept && command == CMD_QUERY) begin
          px  <= pos_x;
          py  <= pos_y;
          idx <= '0;
          fx  <= '0;
          fy  <= '0;
          pot <= '0;
        end
      end
      ST_LOAD: begin
        adx  <= adx_w[POS_W-1:0];
        ady  <= ady_w[POS_W-1:0];
        sx   <= dx_w[POS_W];
        sy   <= dy_w[POS_W];
        mass <= rentry.mass;
      end
      ST_SQUARE_X: sqx <= adx * adx;
      ST_SQUARE_Y: d2  <= {{(D2_W-2*POS_W){1'b0}}, sqx} + {{(D2_W-2*POS_W){1'b0}}, sqy};
      ST_SQRT_WAIT: begin
        if (sqrt_done) begin
          dd <= root_d * root_d;
        end
      end
      ST_CUBE_LO: begin
        clo <= dd[DIST_W-1:0] * root_d;
        chi <= dd[2*DIST_W-1:DIST_W] * root_d;
      end
      ST_CUBE_SUM: begin
        cube <= {chi, {DIST_W{1'b0}}} + {{DIST_W{1'b0}}, clo};
      end
      ST_ACC: begin
        fx  <= sat_acc(fx, sx ? -qx : qx);
        fy  <= sat_acc(fy, sy ? -qy : qy);
        pot <= sat_acc(pot, -qp);
      end
      ST_NEXT: idx <= idx_inc;
      default: begin
      end
    endcase
  end

  // fill count never passes the table depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_ATTRACTORS))
    else $error("fill count beyond table depth");

  // a query on an empty table answers in the next cycle
  a_empty_query: assert property (@(posedge clk) disable iff (rst)
    (accept && command == CMD_QUERY && count == '0) |=> done)
    else $error("empty query not answered at once");

  // the three dividers run in lockstep
  a_div_lockstep: assert property (@(posedge clk) disable iff (rst)
    (divx_done == divy_done) && (divx_done == divp_done))
    else $error("dividers out of step");

  // done is a single-cycle pulse
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held longer than one cycle");

  // the table is never written during a query walk
  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == ST_IDLE) && !full)
    else $error("table write outside idle");

endmodule
`default_nettype wire
